// ===== rtl/core/fcl_pkg.sv =====
// Shared types, constants and helpers for the dense layer engine.
// No dependencies; fcl_front, fcl_back and the top level import this package.
`timescale 1ns / 1ps
package fcl_pkg;

  localparam int MAX_INPUTS  = 16;
  localparam int MAX_OUTPUTS = 16;
  localparam int BATCH_SLOTS = 8;
  localparam int IDX_W       = 4;
  localparam int SLOT_W      = 3;
  localparam int W_DEPTH     = MAX_INPUTS * MAX_OUTPUTS;
  localparam int A_DEPTH     = BATCH_SLOTS * MAX_INPUTS;
  localparam int W_AW        = $clog2(W_DEPTH);
  localparam int A_AW        = $clog2(A_DEPTH);
  localparam int ACC_W       = 40;

  localparam logic [2:0] MODE_WR_WEIGHT = 3'd0;
  localparam logic [2:0] MODE_WR_BIAS   = 3'd1;
  localparam logic [2:0] MODE_FORWARD   = 3'd2;
  localparam logic [2:0] MODE_BACKWARD  = 3'd3;
  localparam logic [2:0] MODE_RD_WGRAD  = 3'd4;
  localparam logic [2:0] MODE_RD_BGRAD  = 3'd5;

  localparam logic REG_INPUT_COUNT  = 1'b0;
  localparam logic REG_OUTPUT_COUNT = 1'b1;

  typedef enum logic [5:0] {
    OP_WR_WEIGHT = 6'b000001,
    OP_WR_BIAS   = 6'b000010,
    OP_FORWARD   = 6'b000100,
    OP_BACKWARD  = 6'b001000,
    OP_RD_WGRAD  = 6'b010000,
    OP_RD_BGRAD  = 6'b100000
  } op_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [2:0]        sample;
    logic [3:0]        row;
    logic [3:0]        col;
    logic signed [15:0] value;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [3:0]         index;
    logic               final_res;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] sample;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic signed [15:0] value;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] ni_m1;
    logic [IDX_W-1:0] no_m1;
  } cfg_t;

  typedef struct packed {
    logic       idle;
    logic [1:0] out_cnt;
  } back_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32'sh7fffffff);
    lo = -ACC_W'(33'sh080000000);
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic [IDX_W-1:0] count_m1(input logic [4:0] c);
    logic [4:0] n;
    if (c == 5'd0) n = 5'd1;
    else if (c > 5'(MAX_INPUTS < 16 ? MAX_INPUTS : 16)) n = 5'(MAX_INPUTS < 16 ? MAX_INPUTS : 16);
    else n = c;
    count_m1 = IDX_W'(n - 5'd1);
  endfunction

endpackage

// ===== rtl/core/fcl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module fcl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fcl_front.sv =====
// Front end: accepts input items, decodes the mode and queues commands.
// Depends on fcl_pkg.
`timescale 1ns / 1ps
module fcl_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  fcl_pkg::in_item_t in_item,
  output logic             cmd_valid,
  output fcl_pkg::cmd_t    cmd,
  input  logic             cmd_take
);
  import fcl_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       dec_ok;
  cmd_t       dec;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    dec_ok     = 1'b1;
    dec.op     = OP_WR_WEIGHT;
    dec.sample = in_item.sample;
    dec.row    = in_item.row;
    dec.col    = in_item.col;
    dec.value  = in_item.value;
    dec.last   = in_item.last;
    case (in_item.mode)
      MODE_WR_WEIGHT: dec.op = OP_WR_WEIGHT;
      MODE_WR_BIAS:   dec.op = OP_WR_BIAS;
      MODE_FORWARD:   dec.op = OP_FORWARD;
      MODE_BACKWARD:  dec.op = OP_BACKWARD;
      MODE_RD_WGRAD:  dec.op = OP_RD_WGRAD;
      MODE_RD_BGRAD:  dec.op = OP_RD_BGRAD;
      default:        dec_ok = 1'b0;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full && dec_ok;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/core/fcl_back.sv =====
// Back end: sequencer with one shared MAC, stores and the result queue.
// Depends on fcl_pkg and fcl_ram.
`timescale 1ns / 1ps
module fcl_back (
  input  logic                clk,
  input  logic                rst,
  input  fcl_pkg::cfg_t       cfg,
  input  logic                cmd_valid,
  input  fcl_pkg::cmd_t       cmd_in,
  output logic                cmd_take,
  output logic                empty,
  input  logic                pop,
  output fcl_pkg::out_item_t  out_item,
  output fcl_pkg::back_stat_t stat
);
  import fcl_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_FRD   = 15'b000000000000010,
    S_FMUL  = 15'b000000000000100,
    S_FACC  = 15'b000000000001000,
    S_FEMIT = 15'b000000000010000,
    S_BRD   = 15'b000000000100000,
    S_BMUL  = 15'b000000001000000,
    S_BACC  = 15'b000000010000000,
    S_BEMIT = 15'b000000100000000,
    S_GRD   = 15'b000001000000000,
    S_GMUL  = 15'b000010000000000,
    S_GWR   = 15'b000100000000000,
    S_BGU   = 15'b001000000000000,
    S_RRD   = 15'b010000000000000,
    S_REMIT = 15'b100000000000000
  } state_t;

  state_t                   state;
  state_t                   state_next;
  cmd_t                     cmd;
  logic [IDX_W-1:0]         i;
  logic [IDX_W-1:0]         j;
  logic signed [ACC_W-1:0]  acc;
  logic signed [31:0]       prod;
  logic signed [31:0]       wg_old;
  logic                     bwd_open;
  logic signed [15:0]       bias [MAX_OUTPUTS];
  logic signed [31:0]       bgrad [MAX_OUTPUTS];
  logic signed [15:0]       gbuf [MAX_OUTPUTS];
  logic [W_DEPTH-1:0]       wg_valid;

  logic                     w_we;
  logic [W_AW-1:0]          w_raddr;
  logic [15:0]              w_rdata;
  logic                     a_we;
  logic [A_AW-1:0]          a_raddr;
  logic [15:0]              a_rdata;
  logic                     g_we;
  logic [W_AW-1:0]          g_raddr;
  logic [W_AW-1:0]          g_waddr;
  logic signed [31:0]       g_wdata;
  logic [31:0]              g_rdata;

  out_item_t                oq [2];
  logic                     o_wr;
  logic                     o_rd;
  logic [1:0]               o_cnt;
  logic                     o_full;
  logic                     o_push;
  out_item_t                o_item;
  logic                     o_pop;
  logic                     start;
  logic                     clr;

  assign start    = (state == S_IDLE) && cmd_valid;
  assign cmd_take = (state == S_IDLE);
  assign clr      = start && (cmd_in.op == OP_BACKWARD) && !bwd_open &&
                    (cmd_in.sample == '0);
  assign o_full   = (o_cnt == 2'd2);
  assign o_pop    = pop && !empty;
  assign empty    = (o_cnt == 2'd0);
  assign out_item = oq[o_rd];
  assign stat     = '{idle: (state == S_IDLE), out_cnt: o_cnt};

  assign w_we    = start && (cmd_in.op == OP_WR_WEIGHT);
  assign a_we    = start && (cmd_in.op == OP_FORWARD);
  assign w_raddr = {i, j};
  assign a_raddr = {cmd.sample, i};
  assign g_raddr = (state == S_RRD || state == S_REMIT) ? {cmd.row, cmd.col} : {i, j};
  assign g_waddr = {i, j};
  assign g_we    = (state == S_GWR);
  assign g_wdata = sat32(ACC_W'(wg_old) + ACC_W'(prod));

  fcl_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_weight (
    .clk(clk), .we(w_we), .waddr({cmd_in.row, cmd_in.col}), .wdata(cmd_in.value),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  fcl_ram #(.WIDTH(16), .DEPTH(A_DEPTH)) u_act (
    .clk(clk), .we(a_we), .waddr({cmd_in.sample, cmd_in.row}), .wdata(cmd_in.value),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  fcl_ram #(.WIDTH(32), .DEPTH(W_DEPTH)) u_wgrad (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  always_comb begin
    o_push     = 1'b0;
    o_item     = '{result: sat32(acc), index: j, final_res: (j == cfg.no_m1)};
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd_in.op)
            OP_FORWARD:  if (cmd_in.last) state_next = S_FRD;
            OP_BACKWARD: if (cmd_in.last) state_next = S_BRD;
            OP_RD_WGRAD: state_next = S_RRD;
            OP_RD_BGRAD: state_next = S_REMIT;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_FRD:   state_next = S_FMUL;
      S_FMUL:  state_next = S_FACC;
      S_FACC:  state_next = (i == cfg.ni_m1) ? S_FEMIT : S_FRD;
      S_FEMIT: begin
        o_push = !o_full;
        if (!o_full) state_next = (j == cfg.no_m1) ? S_IDLE : S_FRD;
      end
      S_BRD:   state_next = S_BMUL;
      S_BMUL:  state_next = S_BACC;
      S_BACC:  state_next = (j == cfg.no_m1) ? S_BEMIT : S_BRD;
      S_BEMIT: begin
        o_push = !o_full;
        o_item = '{result: sat32(acc), index: i, final_res: (i == cfg.ni_m1)};
        if (!o_full) state_next = (i == cfg.ni_m1) ? S_GRD : S_BRD;
      end
      S_GRD:   state_next = S_GMUL;
      S_GMUL:  state_next = S_GWR;
      S_GWR:   state_next = (i == cfg.ni_m1 && j == cfg.no_m1) ? S_BGU : S_GRD;
      S_BGU:   state_next = (j == cfg.no_m1) ? S_IDLE : S_BGU;
      S_RRD:   state_next = S_REMIT;
      S_REMIT: begin
        o_push = !o_full;
        o_item = '{result: (cmd.op == OP_RD_WGRAD) ?
                   (wg_valid[{cmd.row, cmd.col}] ? g_rdata : 32'sd0) : acc[31:0],
                   index: cmd.col, final_res: 1'b1};
        if (!o_full) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) cmd <= cmd_in;
    if (start && cmd_in.op == OP_BACKWARD) gbuf[cmd_in.col] <= cmd_in.value;
    if (o_push) oq[o_wr] <= o_item;
    case (state)
      S_IDLE: begin
        i <= '0;
        j <= '0;
        acc <= (cmd_in.op == OP_RD_BGRAD) ? ACC_W'(bgrad[cmd_in.col]) :
               (cmd_in.op == OP_FORWARD) ? (ACC_W'(bias[0]) <<< 12) : '0;
      end
      S_FMUL: prod <= $signed(a_rdata) * $signed(w_rdata);
      S_FACC: begin
        acc <= acc + ACC_W'(prod);
        if (i != cfg.ni_m1) i <= i + 1'b1;
      end
      S_FEMIT: if (!o_full) begin
        i <= '0;
        j <= j + 1'b1;
        acc <= ACC_W'(bias[j + 1'b1]) <<< 12;
      end
      S_BMUL: prod <= gbuf[j] * $signed(w_rdata);
      S_BACC: begin
        acc <= acc + ACC_W'(prod);
        if (j != cfg.no_m1) j <= j + 1'b1;
      end
      S_BEMIT: if (!o_full) begin
        j <= '0;
        acc <= '0;
        i <= (i == cfg.ni_m1) ? '0 : i + 1'b1;
      end
      S_GMUL: begin
        prod <= $signed(a_rdata) * gbuf[j];
        wg_old <= wg_valid[{i, j}] ? g_rdata : 32'sd0;
      end
      S_GWR: begin
        if (j == cfg.no_m1) begin
          j <= '0;
          i <= i + 1'b1;
        end else begin
          j <= j + 1'b1;
        end
      end
      S_BGU: j <= j + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      bwd_open <= 1'b0;
      wg_valid <= '0;
      o_wr     <= 1'b0;
      o_rd     <= 1'b0;
      o_cnt    <= 2'd0;
      for (int k = 0; k < MAX_OUTPUTS; k++) begin
        bias[k]  <= '0;
        bgrad[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (start && cmd_in.op == OP_WR_BIAS) bias[cmd_in.col] <= cmd_in.value;
      if (start && cmd_in.op == OP_BACKWARD) bwd_open <= !cmd_in.last;
      if (clr) begin
        wg_valid <= '0;
        for (int k = 0; k < MAX_OUTPUTS; k++) bgrad[k] <= '0;
      end
      if (g_we) wg_valid[g_waddr] <= 1'b1;
      if (state == S_BGU) begin
        bgrad[j] <= sat32(ACC_W'(bgrad[j]) + (ACC_W'(gbuf[j]) <<< 12));
      end
      if (o_push) o_wr <= !o_wr;
      if (o_pop) o_rd <= !o_rd;
      o_cnt <= o_cnt + 2'(o_push) - 2'(o_pop);
    end
  end

endmodule

// ===== rtl/core/fully_connected_layer_engine.sv =====
// Top level of the dense layer engine: config registers, front and back.
// Depends on fcl_pkg, fcl_front, fcl_back.
//
//   channel  | handshake          | payload
//   input    | push / full        | in_item  (in_item_t)
//   result   | pop / empty        | out_item (out_item_t)
//   config   | psel/penable/pwrite| paddr, pwdata, prdata
//
// Write items and gradient reads are served one at a time; the front drops ignored
// modes as they arrive. A forward last item multiplies and accumulates each output
// over the inputs, emits it; a backward last item does so per input, then updates
// the weight and bias gradients, paced by the shared MAC and its RAM read ports.
// Reset is synchronous; no clearing pass is needed after it.
// A full result queue stalls the back end; the two-entry command queue stalls push.
`timescale 1ns / 1ps
module fully_connected_layer_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  fcl_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output fcl_pkg::out_item_t out_item
);
  import fcl_pkg::*;

  logic [4:0]  input_count;
  logic [4:0]  output_count;
  cfg_t        cfg;
  logic        cmd_valid;
  cmd_t        cmd;
  logic        cmd_take;
  back_stat_t  stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OUTPUT_COUNT) ? {27'd0, output_count} :
                                                   {27'd0, input_count};
  assign cfg    = '{ni_m1: count_m1(input_count), no_m1: count_m1(output_count)};

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count  <= 5'd16;
      output_count <= 5'd16;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_INPUT_COUNT) input_count <= pwdata[4:0];
      else output_count <= pwdata[4:0];
    end
  end

  fcl_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  fcl_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd_valid(cmd_valid), .cmd_in(cmd),
    .cmd_take(cmd_take), .empty(empty), .pop(pop), .out_item(out_item), .stat(stat)
  );

`ifndef ASSERT_OFF
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");
  a_oq_bound: assert property (@(posedge clk) disable iff (rst) stat.out_cnt != 2'd3)
    else $error("result queue overflow");
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    empty == (stat.out_cnt == 2'd0))
    else $error("empty disagrees with result queue count");
`endif

endmodule
